[rtl/med_pkg.sv]
`default_nettype none
package med_pkg;
  localparam int NODE_COUNT      = 4096;
  localparam int FACETS_PER_NODE = 8;
  localparam int FACET_LIMIT     = 16384;
  localparam int NODE_W          = 12;
  localparam int ELEM_W          = 16;
  localparam int FID_W           = 14;
  localparam int CNT_W           = 15;
  localparam logic [CNT_W-1:0] INNER_MAX = 15'd32767;

  localparam logic [1:0] ST_NEW   = 2'd0;
  localparam logic [1:0] ST_INNER = 2'd1;
  localparam logic [1:0] ST_LFULL = 2'd2;
  localparam logic [1:0] ST_SFULL = 2'd3;

  typedef struct packed {
    logic [NODE_W-1:0] a;
    logic [NODE_W-1:0] b;
    logic [ELEM_W-1:0] elem;
    logic              last;
  } edge_job_t;

  typedef struct packed {
    logic [FID_W-1:0]  facet_id;
    logic [1:0]        status;
    logic [NODE_W-1:0] node_a;
    logic [NODE_W-1:0] node_b;
    logic [ELEM_W-1:0] owner_elem;
    logic [CNT_W-1:0]  facet_count;
    logic [CNT_W-1:0]  inner_count;
    logic              last;
  } result_t;
endpackage
`default_nettype wire

[rtl/mesh_edge_dedup.sv]
`default_nettype none
// edges: 3..5 per element (corners clamped to that range), none for a patch element
// loop: one shared list memory read per cycle in the back end
// reset: synchronous, active low; a clearing pass over the list lengths follows;
// the front may take elements meanwhile, but no edge is searched before it ends
module mesh_edge_dedup #(
  parameter int NODE_COUNT      = med_pkg::NODE_COUNT,
  parameter int FACETS_PER_NODE = med_pkg::FACETS_PER_NODE,
  parameter int FACET_LIMIT     = med_pkg::FACET_LIMIT
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  output logic             full,
  input  wire logic [15:0] in_elem_id,
  input  wire logic [2:0]  in_corners,
  input  wire logic [11:0] in_node0,
  input  wire logic [11:0] in_node1,
  input  wire logic [11:0] in_node2,
  input  wire logic [11:0] in_node3,
  input  wire logic [11:0] in_node4,
  input  wire logic        in_patch,
  output logic             empty,
  input  wire logic        pop,
  output logic [13:0]      out_facet_id,
  output logic [1:0]       out_status,
  output logic [11:0]      out_node_a,
  output logic [11:0]      out_node_b,
  output logic [15:0]      out_owner_elem,
  output logic [14:0]      out_facet_count,
  output logic [14:0]      out_inner_count,
  output logic             out_last
);
  // front to queue
  logic f_v, f_rdy, q_v, q_rdy, r_v;
  med_pkg::edge_job_t f_job, q_job;
  med_pkg::result_t   r;

  med_front u_front (
    .clk, .rst_n, .push, .full,
    .elem_id(in_elem_id), .corners(in_corners),
    .node0(in_node0), .node1(in_node1), .node2(in_node2),
    .node3(in_node3), .node4(in_node4), .patch(in_patch),
    .job_valid(f_v), .job_ready(f_rdy), .job(f_job)
  );

  // short edge queue decouples splitting from searching
  med_queue #(.DEPTH(4)) u_queue (
    .clk, .rst_n, .wr_valid(f_v), .wr_ready(f_rdy), .wr_data(f_job),
    .rd_valid(q_v), .rd_ready(q_rdy), .rd_data(q_job)
  );

  med_back #(
    .NODE_COUNT(NODE_COUNT), .FACETS_PER_NODE(FACETS_PER_NODE),
    .FACET_LIMIT(FACET_LIMIT)
  ) u_back (
    .clk, .rst_n, .job_valid(q_v), .job_ready(q_rdy), .job(q_job),
    .res_valid(r_v), .res_ready(pop), .res(r)
  );

  assign empty           = !r_v;
  assign out_facet_id    = r.facet_id;
  assign out_status      = r.status;
  assign out_node_a      = r.node_a;
  assign out_node_b      = r.node_b;
  assign out_owner_elem  = r.owner_elem;
  assign out_facet_count = r.facet_count;
  assign out_inner_count = r.inner_count;
  assign out_last        = r.last;
endmodule
`default_nettype wire

[rtl/med_front.sv]
`default_nettype none
// splits one element into edge jobs, one per cycle while job_ready is high; patch elements are dropped
module med_front (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        push,
  output logic                             full,
  input  wire logic [med_pkg::ELEM_W-1:0]  elem_id,
  input  wire logic [2:0]                  corners,
  input  wire logic [med_pkg::NODE_W-1:0]  node0,
  input  wire logic [med_pkg::NODE_W-1:0]  node1,
  input  wire logic [med_pkg::NODE_W-1:0]  node2,
  input  wire logic [med_pkg::NODE_W-1:0]  node3,
  input  wire logic [med_pkg::NODE_W-1:0]  node4,
  input  wire logic                        patch,
  output logic                             job_valid,
  input  wire logic                        job_ready,
  output med_pkg::edge_job_t               job
);
  logic                       busy_r;
  logic [2:0]                 k_r, n_r;
  logic [med_pkg::ELEM_W-1:0] elem_r;
  logic [med_pkg::NODE_W-1:0] nodes_r [5];
  logic [2:0]                 n_clamp, k_next;

  always_comb begin
    if (corners < 3'd3) n_clamp = 3'd3;
    else if (corners > 3'd5) n_clamp = 3'd5;
    else n_clamp = corners;
    k_next = (k_r + 3'd1 == n_r) ? 3'd0 : k_r + 3'd1;
  end

  assign full      = busy_r;
  assign job_valid = busy_r;
  assign job.a     = nodes_r[k_r];
  assign job.b     = nodes_r[k_next];
  assign job.elem  = elem_r;
  assign job.last  = (k_r + 3'd1 == n_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      k_r    <= 3'd0;
    end else if (!busy_r) begin
      if (push && !patch) begin
        busy_r <= 1'b1;
        k_r    <= 3'd0;
      end
    end else if (job_ready) begin
      k_r <= k_next;
      if (job.last) busy_r <= 1'b0;
    end
    if (!busy_r && push) begin
      n_r        <= n_clamp;
      elem_r     <= elem_id;
      nodes_r[0] <= node0;
      nodes_r[1] <= node1;
      nodes_r[2] <= node2;
      nodes_r[3] <= node3;
      nodes_r[4] <= node4;
    end
  end
endmodule
`default_nettype wire

[rtl/med_queue.sv]
`default_nettype none
// small fifo of edge jobs between front and back
module med_queue #(
  parameter int DEPTH = 4
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               wr_valid,
  output logic                    wr_ready,
  input  wire med_pkg::edge_job_t wr_data,
  output logic                    rd_valid,
  input  wire logic               rd_ready,
  output med_pkg::edge_job_t      rd_data
);
  localparam int AW = $clog2(DEPTH);
  med_pkg::edge_job_t mem_r [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r;
  logic wr, rd;

  assign wr_ready = (cnt_r != (AW+1)'(DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_data  = mem_r[rp_r];
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (wr) wp_r <= (wp_r == AW'(DEPTH-1)) ? '0 : wp_r + 1'b1;
      if (rd) rp_r <= (rp_r == AW'(DEPTH-1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(wr) - (AW+1)'(rd);
    end
    if (wr) mem_r[wp_r] <= wr_data;
  end
endmodule
`default_nettype wire

[rtl/med_back.sv]
`default_nettype none
// searches node lists and appends new facets, one list memory read per cycle
module med_back #(
  parameter int NODE_COUNT      = med_pkg::NODE_COUNT,
  parameter int FACETS_PER_NODE = med_pkg::FACETS_PER_NODE,
  parameter int FACET_LIMIT     = med_pkg::FACET_LIMIT
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               job_valid,
  output logic                    job_ready,
  input  wire med_pkg::edge_job_t job,
  output logic                    res_valid,
  input  wire logic               res_ready,
  output med_pkg::result_t        res
);
  localparam int NA  = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
  localparam int LA  = $clog2(FACETS_PER_NODE);
  localparam int LW  = $clog2(FACETS_PER_NODE + 1);
  localparam int FW  = $clog2(FACET_LIMIT + 1);
  localparam int CLR = NODE_COUNT;

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_LEN  = 4'd2;
  localparam logic [3:0] S_RDA  = 4'd3;
  localparam logic [3:0] S_GETA = 4'd4;
  localparam logic [3:0] S_RDB  = 4'd5;
  localparam logic [3:0] S_CMPB = 4'd6;
  localparam logic [3:0] S_DEC  = 4'd7;
  localparam logic [3:0] S_APB  = 4'd8;
  localparam logic [3:0] S_OUT  = 4'd9;

  logic [med_pkg::FID_W-1:0] list_mem [NODE_COUNT*(1 << LA)];
  logic [LW-1:0]             len_mem  [NODE_COUNT];

  logic [3:0]    st_r;
  logic [NA:0]   clr_r;
  med_pkg::edge_job_t j_r;
  logic          va_r, vb_r;
  logic [LW-1:0] la_r, lb_r, i_r, jj_r;
  logic [med_pkg::FID_W-1:0] fa_r, rd_r;
  logic [LW-1:0] lrd_r;
  logic [FW-1:0] made_r;
  logic [med_pkg::CNT_W-1:0] inner_r;
  logic          found_r;
  med_pkg::result_t out_r;
  logic          out_v_r;

  logic [NA-1:0] na, nb;
  logic [NA+LA-1:0] addr;
  logic              mwe;
  logic [NA+LA-1:0]  waddr;
  logic [med_pkg::FID_W-1:0] wdata;
  logic              lwe;
  logic [NA-1:0]     lwaddr;
  logic [LW-1:0]     lwdata;

  assign na = NA'(j_r.a);
  assign nb = NA'(j_r.b);
  assign job_ready = (st_r == S_IDLE);
  assign res_valid = out_v_r;
  assign res       = out_r;

  always_comb begin
    addr = {na, i_r[LA-1:0]};
    if (st_r == S_RDB) addr = {nb, jj_r[LA-1:0]};
  end

  always_ff @(posedge clk) begin
    rd_r <= list_mem[addr];
    if (mwe) list_mem[waddr] <= wdata;
  end
  always_ff @(posedge clk) begin
    lrd_r <= len_mem[(st_r == S_IDLE) ? NA'(job.a) : nb];
    if (lwe) len_mem[lwaddr] <= lwdata;
  end

  logic room;
  always_comb begin
    if (!va_r || !vb_r) room = 1'b0;
    else if (j_r.a == j_r.b) room = (32'(la_r) + 2 <= FACETS_PER_NODE);
    else room = (32'(la_r) < FACETS_PER_NODE) && (32'(lb_r) < FACETS_PER_NODE);
  end

  always_comb begin
    mwe = 1'b0; waddr = {na, la_r[LA-1:0]}; wdata = made_r[med_pkg::FID_W-1:0];
    lwe = 1'b0; lwaddr = na; lwdata = la_r + 1'b1;
    if (st_r == S_CLR) begin
      lwe = 1'b1; lwaddr = clr_r[NA-1:0]; lwdata = '0;
    end else if (st_r == S_DEC && !found_r && 32'(made_r) < FACET_LIMIT && room) begin
      mwe = 1'b1; lwe = 1'b1;
    end else if (st_r == S_APB) begin
      mwe = 1'b1; lwe = 1'b1; lwaddr = nb;
      // equal nodes: second entry goes right after the first
      waddr = (j_r.a == j_r.b) ? {nb, LA'(la_r + 1'b1)} : {nb, lb_r[LA-1:0]};
      lwdata = (j_r.a == j_r.b) ? la_r + LW'(2) : lb_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_CLR; clr_r <= '0; made_r <= '0; inner_r <= '0; out_v_r <= 1'b0;
    end else begin
      if (res_ready && out_v_r) out_v_r <= 1'b0;
      unique case (st_r)
        S_CLR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == (NA+1)'(CLR-1)) st_r <= S_IDLE;
        end
        S_IDLE: if (job_valid) begin
          j_r <= job;
          va_r <= (32'(job.a) < NODE_COUNT);
          vb_r <= (32'(job.b) < NODE_COUNT);
          st_r <= S_LEN;
        end
        S_LEN: begin
          la_r <= va_r ? lrd_r : '0;
          st_r <= S_RDA;
        end
        S_RDA: begin
          lb_r <= vb_r ? lrd_r : '0;
          i_r <= '0; found_r <= 1'b0;
          st_r <= (la_r == '0) ? S_DEC : S_GETA;
        end
        S_GETA: st_r <= S_RDB;
        S_RDB: begin
          if (st_r == S_RDB && jj_r == '0) fa_r <= rd_r;
          if (jj_r == lb_r) begin
            i_r <= i_r + 1'b1; jj_r <= '0;
            st_r <= (i_r + 1'b1 == la_r) ? S_DEC : S_GETA;
          end else st_r <= S_CMPB;
        end
        S_CMPB: begin
          if (rd_r == fa_r) begin
            found_r <= 1'b1; st_r <= S_DEC;
          end else begin
            jj_r <= jj_r + 1'b1; st_r <= S_RDB;
          end
        end
        S_DEC: if (!out_v_r || res_ready) begin
          out_r.node_a <= j_r.a; out_r.node_b <= j_r.b;
          out_r.owner_elem <= j_r.elem; out_r.last <= j_r.last;
          out_r.inner_count <= inner_r;
          out_r.facet_count <= med_pkg::CNT_W'(made_r);
          out_r.facet_id <= '0;
          st_r <= S_OUT;
          if (found_r) begin
            out_r.status <= med_pkg::ST_INNER; out_r.facet_id <= fa_r;
            if (inner_r < med_pkg::INNER_MAX) begin
              inner_r <= inner_r + 1'b1; out_r.inner_count <= inner_r + 1'b1;
            end
          end else if (32'(made_r) >= FACET_LIMIT) out_r.status <= med_pkg::ST_SFULL;
          else if (!room) out_r.status <= med_pkg::ST_LFULL;
          else begin
            out_r.status <= med_pkg::ST_NEW;
            out_r.facet_id <= made_r[med_pkg::FID_W-1:0];
            out_r.facet_count <= med_pkg::CNT_W'(made_r + 1'b1);
            st_r <= S_APB;
          end
        end
        S_APB: begin
          made_r <= made_r + 1'b1; st_r <= S_OUT;
        end
        S_OUT: begin
          out_v_r <= 1'b1; st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
      if (st_r == S_RDA || st_r == S_IDLE) jj_r <= '0;
    end
  end
endmodule
`default_nettype wire
